// ===== rtl/core/hrhf_pkg.sv =====
package hrhf_pkg;

    localparam int BUF_DEPTH  = 256;
    localparam int AW         = $clog2(BUF_DEPTH);
    localparam int CW         = (AW > 8) ? AW : 8;
    localparam int PREFIX_LEN = 21;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_IDLE    = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [1:0] CODE_REQLINE = 2'd0;
    localparam logic [1:0] CODE_HEADERS = 2'd1;
    localparam logic [1:0] CODE_BODY    = 2'd2;
    localparam logic [1:0] CODE_DONE    = 2'd3;

    typedef enum logic [3:0] {
        PH_REQLINE = 4'b0001,
        PH_HEADERS = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [1:0] parse_phase;
        logic [7:0] kept_length;
        logic       overflowed;
        logic       request_ready;
        logic       read_valid;
    } t_result;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_REQLINE: code = CODE_REQLINE;
            PH_HEADERS: code = CODE_HEADERS;
            PH_BODY:    code = CODE_BODY;
            PH_DONE:    code = CODE_DONE;
            default:    code = CODE_REQLINE;
        endcase
        return code;
    endfunction

    // "Authorization: Basic "
    function automatic logic [7:0] prefix_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos)
            5'd0:    ch = "A";
            5'd1:    ch = "u";
            5'd2:    ch = "t";
            5'd3:    ch = "h";
            5'd4:    ch = "o";
            5'd5:    ch = "r";
            5'd6:    ch = "i";
            5'd7:    ch = "z";
            5'd8:    ch = "a";
            5'd9:    ch = "t";
            5'd10:   ch = "i";
            5'd11:   ch = "o";
            5'd12:   ch = "n";
            5'd13:   ch = ":";
            5'd14:   ch = " ";
            5'd15:   ch = "B";
            5'd16:   ch = "a";
            5'd17:   ch = "s";
            5'd18:   ch = "i";
            5'd19:   ch = "c";
            5'd20:   ch = " ";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/hrhf_ifs.sv =====
interface hrhf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output kind, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input kind, input rx_byte, input read_index,
                    output ready);
endinterface

interface hrhf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] parse_phase;
    logic [7:0] kept_length;
    logic       overflowed;
    logic       request_ready;
    logic [7:0] read_data;
    logic       read_valid;

    modport source (output valid, output parse_phase, output kept_length,
                    output overflowed, output request_ready, output read_data,
                    output read_valid, input ready);
    modport sink   (input valid, input parse_phase, input kept_length,
                    input overflowed, input request_ready, input read_data,
                    input read_valid, output ready);
endinterface

// ===== rtl/core/http_request_header_filter.sv =====
// channel  | dir | transfer moves
// ---------+-----+------------------------------------------------------------
// i_req    | in  | kind, rx_byte, read_index
// o_rsp    | out | parse_phase, kept_length, overflowed, request_ready,
//          |     | read_data, read_valid
//
// One request item per cycle while o_rsp does not stall. The transfer edge registers
// the parser result together with the read of the kept-byte RAM; the output stage then
// loads from that stage once it is free, and the response transfers from the output stage.
// Parser state updates at the input transfer, so bytes stream back to back.
// Synchronous active-low reset clears the parser and both pipeline stages;
// the RAM keeps its contents. A stalled o_rsp holds the output stage, then
// the RAM stage, then drops i_req.ready.
module http_request_header_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrhf_in_if.sink     i_req,
    hrhf_out_if.source  o_rsp
);

    hrhf_pkg::t_ram_req ram_req;
    hrhf_pkg::t_result  res;
    logic [7:0]         ram_rdata;

    logic               r_s1_valid;
    hrhf_pkg::t_result  r_s1;
    logic               r_out_valid;
    hrhf_pkg::t_result  r_out;
    logic [7:0]         r_out_data;

    logic s1_move;
    logic in_ready;
    logic accept;

    assign s1_move  = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_s1_valid || s1_move;
    assign accept   = i_req.valid && in_ready;

    hrhf_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_kind       (i_req.kind),
        .i_rx_byte    (i_req.rx_byte),
        .i_read_index (i_req.read_index),
        .o_ram        (ram_req),
        .o_res        (res)
    );

    hrhf_ram #(
        .WIDTH (8),
        .DEPTH (hrhf_pkg::BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
        if (s1_move) begin
            r_out      <= r_s1;
            r_out_data <= r_s1.read_valid ? ram_rdata : 8'h00;
        end
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.parse_phase   = r_out.parse_phase;
    assign o_rsp.kept_length   = r_out.kept_length;
    assign o_rsp.overflowed    = r_out.overflowed;
    assign o_rsp.request_ready = r_out.request_ready;
    assign o_rsp.read_data     = r_out_data;
    assign o_rsp.read_valid    = r_out.read_valid;

endmodule

// ===== rtl/core/hrhf_ram.sv =====
module hrhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hrhf_parse.sv =====
module hrhf_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_rx_byte,
    input  logic [7:0]         i_read_index,
    output hrhf_pkg::t_ram_req o_ram,
    output hrhf_pkg::t_result  o_res
);

    localparam int AW = hrhf_pkg::AW;
    localparam int CW = hrhf_pkg::CW;

    hrhf_pkg::t_phase r_phase, n_phase;
    logic [AW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_line_begin, n_line_begin;
    logic             r_line_blank, n_line_blank;
    logic [4:0]       r_prefix_pos, n_prefix_pos;
    logic             r_prefix_ok, n_prefix_ok;
    logic             r_ovf, n_ovf;

    always_comb begin
        logic [AW-1:0] t_fill;
        logic [4:0]    t_pos;
        logic          t_ok;
        logic [CW-1:0] fill_ext;
        n_phase      = r_phase;
        n_fill       = r_fill;
        n_line_begin = r_line_begin;
        n_line_blank = r_line_blank;
        n_prefix_pos = r_prefix_pos;
        n_prefix_ok  = r_prefix_ok;
        n_ovf        = r_ovf;
        t_fill       = r_fill;
        t_pos        = r_prefix_pos;
        t_ok         = r_prefix_ok;
        o_ram        = '0;
        o_res        = '0;
        if (i_accept) begin
            case (i_kind)
                hrhf_pkg::KIND_BYTE: begin
                    if (r_phase != hrhf_pkg::PH_DONE) begin
                        if (r_fill < AW'(hrhf_pkg::BUF_DEPTH - 1)) begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = r_fill;
                            o_ram.wdata = i_rx_byte;
                            t_fill      = r_fill + AW'(1);
                            if (r_prefix_pos < 5'(hrhf_pkg::PREFIX_LEN)) begin
                                if (i_rx_byte != hrhf_pkg::prefix_char(r_prefix_pos)) begin
                                    t_ok = 1'b0;
                                end
                                t_pos = r_prefix_pos + 5'd1;
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_prefix_pos = t_pos;
                        n_prefix_ok  = t_ok;
                        if (i_rx_byte == hrhf_pkg::CH_LF) begin
                            case (r_phase)
                                hrhf_pkg::PH_REQLINE: begin
                                    n_phase      = hrhf_pkg::PH_HEADERS;
                                    n_line_begin = t_fill;
                                end
                                hrhf_pkg::PH_HEADERS: begin
                                    if (r_line_blank) begin
                                        n_phase = hrhf_pkg::PH_BODY;
                                    end else if (t_ok &&
                                                 t_pos >= 5'(hrhf_pkg::PREFIX_LEN)) begin
                                        n_line_begin = t_fill;
                                    end else begin
                                        t_fill = r_line_begin;
                                    end
                                end
                                default: begin
                                    n_line_begin = t_fill;
                                    n_phase      = hrhf_pkg::PH_DONE;
                                end
                            endcase
                            n_line_blank = 1'b1;
                            n_prefix_pos = 5'd0;
                            n_prefix_ok  = 1'b1;
                        end else if (i_rx_byte != hrhf_pkg::CH_CR) begin
                            n_line_blank = 1'b0;
                        end
                        n_fill = t_fill;
                    end
                end
                hrhf_pkg::KIND_IDLE: begin
                    if (r_phase == hrhf_pkg::PH_BODY) begin
                        n_phase = hrhf_pkg::PH_DONE;
                    end
                end
                hrhf_pkg::KIND_READ: begin
                    if (CW'(i_read_index) < CW'(r_fill)) begin
                        o_ram.re       = 1'b1;
                        o_ram.raddr    = AW'(i_read_index);
                        o_res.read_valid = 1'b1;
                    end
                end
                default: begin
                    n_phase      = hrhf_pkg::PH_REQLINE;
                    n_fill       = '0;
                    n_line_begin = '0;
                    n_line_blank = 1'b1;
                    n_prefix_pos = 5'd0;
                    n_prefix_ok  = 1'b1;
                    n_ovf        = 1'b0;
                end
            endcase
        end
        fill_ext            = CW'(n_fill);
        o_res.parse_phase   = hrhf_pkg::phase_code(n_phase);
        o_res.kept_length   = fill_ext[7:0];
        o_res.overflowed    = n_ovf;
        o_res.request_ready = (n_phase == hrhf_pkg::PH_DONE) && (n_fill != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hrhf_pkg::PH_REQLINE;
            r_fill       <= '0;
            r_line_begin <= '0;
            r_line_blank <= 1'b1;
            r_prefix_pos <= 5'd0;
            r_prefix_ok  <= 1'b1;
            r_ovf        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_fill       <= n_fill;
            r_line_begin <= n_line_begin;
            r_line_blank <= n_line_blank;
            r_prefix_pos <= n_prefix_pos;
            r_prefix_ok  <= n_prefix_ok;
            r_ovf        <= n_ovf;
        end
    end

endmodule

// ===== tb/tb_http_request_header_filter.sv =====
module tb_http_request_header_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import hrhf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 8;
    localparam int ITEMS_PER_STAGE = 550;

    localparam logic [8*PREFIX_LEN-1:0] AUTH_TEXT = "Authorization: Basic ";

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } filt_req_t;

    typedef struct packed {
        logic [1:0] parse_phase;
        logic [7:0] kept_length;
        logic       overflowed;
        logic       request_ready;
        logic [7:0] read_data;
        logic       read_valid;
    } filt_rsp_t;

    logic i_clk;
    logic i_rst_n;

    hrhf_in_if  req_if ();
    hrhf_out_if rsp_if ();

    http_request_header_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // parser shadow state
    logic [1:0]    ph_q;
    logic [CW-1:0] fill_q;
    logic [CW-1:0] line_start_q;
    logic          blank_q;
    logic [4:0]    auth_pos_q;
    logic          auth_match_q;
    logic          ovf_q;
    logic [7:0]    kept_mirror [BUF_DEPTH];

    filt_req_t pending_reqs [$];
    filt_rsp_t expected_rsps [$];

    int  queued_cnt;
    int  checked_cnt;
    int  err_cnt;
    int  stall_cycles;
    int  src_idle_pct;
    int  snk_idle_pct;
    logic req_taken;

    function automatic logic [7:0] prefix_byte(input int i);
        return AUTH_TEXT[8*(PREFIX_LEN-1-i) +: 8];
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(255));
    endfunction

    function automatic void clear_parse();
        ph_q         = CODE_REQLINE;
        fill_q       = '0;
        line_start_q = '0;
        blank_q      = 1'b1;
        auth_pos_q   = '0;
        auth_match_q = 1'b1;
        ovf_q        = 1'b0;
    endfunction

    function automatic filt_rsp_t filter_apply(input filt_req_t r);
        filt_rsp_t  o;
        logic [7:0] c;
        o = '0;
        c = r.rx_byte;
        case (r.kind)
            KIND_BYTE: begin
                if (ph_q != CODE_DONE) begin
                    if (fill_q < BUF_DEPTH - 1) begin
                        kept_mirror[fill_q] = c;
                        fill_q = fill_q + CW'(1);
                        if (auth_pos_q < PREFIX_LEN) begin
                            if (c != prefix_byte(auth_pos_q))
                                auth_match_q = 1'b0;
                            auth_pos_q = auth_pos_q + 5'd1;
                        end
                    end else begin
                        ovf_q = 1'b1;
                    end
                    if (c == CH_LF) begin
                        case (ph_q)
                            CODE_REQLINE: begin
                                ph_q         = CODE_HEADERS;
                                line_start_q = fill_q;
                            end
                            CODE_HEADERS: begin
                                if (blank_q)
                                    ph_q = CODE_BODY;
                                else if (auth_match_q && auth_pos_q >= PREFIX_LEN)
                                    line_start_q = fill_q;
                                else
                                    fill_q = line_start_q;
                            end
                            default: begin
                                line_start_q = fill_q;
                                ph_q         = CODE_DONE;
                            end
                        endcase
                        blank_q      = 1'b1;
                        auth_pos_q   = '0;
                        auth_match_q = 1'b1;
                    end else if (c != CH_CR) begin
                        blank_q = 1'b0;
                    end
                end
            end
            KIND_IDLE: begin
                if (ph_q == CODE_BODY)
                    ph_q = CODE_DONE;
            end
            KIND_READ: begin
                if (r.read_index < fill_q) begin
                    o.read_data  = kept_mirror[r.read_index];
                    o.read_valid = 1'b1;
                end
            end
            default: clear_parse();
        endcase
        o.parse_phase   = ph_q;
        o.kept_length   = fill_q[7:0];
        o.overflowed    = ovf_q;
        o.request_ready = (ph_q == CODE_DONE) && (fill_q != 0);
        return o;
    endfunction

    task automatic put_item(input logic [1:0] kind, input logic [7:0] b,
                            input logic [7:0] idx);
        pending_reqs.push_back('{kind: kind, rx_byte: b, read_index: idx});
        queued_cnt++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_item(KIND_BYTE, b, rand8());
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_eol();
        if ($urandom_range(2) != 0)
            put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    // first n prefix characters, with one bit flipped at position bad (if any)
    task automatic put_prefix(input int n, input int bad);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = prefix_byte(i);
            if (i == bad) begin
                c = c ^ (8'h01 << $urandom_range(7));
                if (c == CH_LF || c == CH_CR)
                    c = "#";
            end
            put_byte(c);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        filt_req_t nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pending_reqs.pop_front();
                req_if.valid      <= 1'b1;
                req_if.kind       <= nxt.kind;
                req_if.rx_byte    <= nxt.rx_byte;
                req_if.read_index <= nxt.read_index;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        filt_rsp_t got;
        filt_rsp_t want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
                expected_rsps.push_back(filter_apply({req_if.kind, req_if.rx_byte,
                                                      req_if.read_index}));
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.parse_phase, rsp_if.kept_length, rsp_if.overflowed,
                       rsp_if.request_ready, rsp_if.read_data, rsp_if.read_valid};
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response phase=%0d len=%0d ovf=%0b rdy=%0b data=%02h rv=%0b",
                             $time, got.parse_phase, got.kept_length, got.overflowed,
                             got.request_ready, got.read_data, got.read_valid);
                    err_cnt++;
                end else begin
                    want = expected_rsps.pop_front();
                    checked_cnt++;
                    if (got !== want) begin
                        $display("%0t: mismatch expected phase=%0d len=%0d ovf=%0b rdy=%0b data=%02h rv=%0b",
                                 $time, want.parse_phase, want.kept_length, want.overflowed,
                                 want.request_ready, want.read_data, want.read_valid);
                        $display("%0t:          actual   phase=%0d len=%0d ovf=%0b rdy=%0b data=%02h rv=%0b",
                                 $time, got.parse_phase, got.kept_length, got.overflowed,
                                 got.request_ready, got.read_data, got.read_valid);
                        err_cnt++;
                    end
                end
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int   stage_base;
        int   n_hdr;
        int   len;
        bit   big_line;
        bit   big_auth;
        logic [7:0] c;

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_BYTE;
        req_if.rx_byte    = '0;
        req_if.read_index = '0;
        rsp_if.ready      = 1'b0;
        queued_cnt        = 0;
        checked_cnt       = 0;
        err_cnt           = 0;
        stall_cycles      = 0;
        src_idle_pct      = 14;
        snk_idle_pct      = 76;
        clear_parse();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int stage = 0; stage < 3; stage++) begin
            stage_base = queued_cnt;
            case (stage)
                0:       begin src_idle_pct = 14; snk_idle_pct = 76; end
                1:       begin src_idle_pct = 76; snk_idle_pct = 14; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase

            if (stage == 0) begin
                put_item(KIND_RESTART, 8'hFF, 8'hFF);
                put_item(KIND_IDLE, 8'h00, 8'h00);      // idle in request line
                put_byte(8'h00);
                put_byte(8'hFF);
                put_byte(CH_LF);
                put_byte("X");                          // short header, rolled back
                put_byte(CH_LF);
                put_byte(CH_CR);                        // blank line
                put_byte(CH_LF);
                put_byte("Z");
                put_item(KIND_IDLE, 8'hFF, 8'h00);      // idle in body completes
                put_byte("Q");                          // ignored after completion
                put_item(KIND_READ, 8'h00, 8'd0);
                put_item(KIND_READ, 8'hFF, 8'd1);
                put_item(KIND_READ, 8'h00, 8'd5);
                put_item(KIND_READ, 8'h00, 8'd6);
                put_item(KIND_READ, 8'hFF, 8'd255);
                put_item(KIND_RESTART, 8'h00, 8'h00);
                put_item(KIND_READ, 8'h00, 8'd0);
            end

            while (queued_cnt - stage_base < ITEMS_PER_STAGE) begin
                if ($urandom_range(9) == 0) begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        put_item(2'($urandom_range(3)), rand8(), rand8());
                end else begin
                    big_line = 1'b0;
                    big_auth = 1'b0;
                    if ($urandom_range(11) == 0) begin
                        if ($urandom_range(1) == 0)
                            big_line = 1'b1;
                        else
                            big_auth = 1'b1;
                    end
                    if ($urandom_range(7) != 0)
                        put_item(KIND_RESTART, rand8(), rand8());

                    put_text("GET /");
                    len = big_line ? $urandom_range(240, 280) : $urandom_range(0, 8);
                    for (int i = 0; i < len; i++)
                        put_byte(8'($urandom_range(33, 126)));
                    put_text(" HTTP/1.1");
                    put_eol();

                    if (big_auth) begin
                        put_prefix(PREFIX_LEN, -1);
                        len = $urandom_range(230, 260);
                        for (int i = 0; i < len; i++)
                            put_byte(8'($urandom_range(33, 126)));
                        put_eol();
                    end
                    n_hdr = $urandom_range(0, 4);
                    for (int h = 0; h < n_hdr; h++) begin
                        case ($urandom_range(4))
                            0, 1: begin
                                put_prefix(PREFIX_LEN, -1);
                                len = $urandom_range(0, 12);
                                for (int i = 0; i < len; i++)
                                    put_byte(8'($urandom_range(33, 126)));
                            end
                            2: begin
                                put_prefix(PREFIX_LEN, $urandom_range(PREFIX_LEN - 1));
                                len = $urandom_range(0, 6);
                                for (int i = 0; i < len; i++)
                                    put_byte(8'($urandom_range(33, 126)));
                            end
                            3: put_prefix($urandom_range(1, PREFIX_LEN - 1), -1);
                            default: begin
                                put_text("Host: ");
                                len = $urandom_range(0, 10);
                                for (int i = 0; i < len; i++)
                                    put_byte(8'($urandom_range(32, 126)));
                            end
                        endcase
                        put_eol();
                        if ($urandom_range(5) == 0)
                            put_item(($urandom_range(1) == 0) ? KIND_IDLE : KIND_READ,
                                     rand8(), 8'($urandom_range(0, 40)));
                    end

                    case ($urandom_range(3))
                        0:       put_byte(CH_LF);
                        1:       begin put_byte(CH_CR); put_byte(CH_CR); put_byte(CH_LF); end
                        default: begin put_byte(CH_CR); put_byte(CH_LF); end
                    endcase

                    len = $urandom_range(0, 10);
                    for (int i = 0; i < len; i++) begin
                        c = rand8();
                        if (c == CH_LF)
                            c = c ^ 8'h80;
                        put_byte(c);
                    end
                    if ($urandom_range(2) == 0)
                        put_item(KIND_IDLE, rand8(), rand8());
                    else
                        put_byte(CH_LF);

                    if ($urandom_range(3) == 0) begin
                        len = $urandom_range(1, 4);
                        for (int i = 0; i < len; i++)
                            put_byte(rand8());
                    end
                    len = $urandom_range(2, 6);
                    for (int i = 0; i < len; i++)
                        put_item(KIND_READ, rand8(),
                                 ($urandom_range(1) == 0) ? 8'($urandom_range(0, 40))
                                                          : rand8());
                end
            end

            while (checked_cnt != queued_cnt)
                @(negedge i_clk);
            @(posedge i_clk);
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0 && expected_rsps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hrhf_pkg.sv
rtl/core/hrhf_ifs.sv
rtl/core/hrhf_ram.sv
rtl/core/hrhf_parse.sv
rtl/core/http_request_header_filter.sv
tb/tb_http_request_header_filter.sv
